// File: hdl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, suppressed while reset is asserted
`define HHLP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// clocked check that also holds during reset
`define HHLP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/hhlp_pkg.sv
package hhlp_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned RoleW   = 3;
    localparam int unsigned StateW  = 4;
    localparam int unsigned OffsetW = 10;

    localparam logic [OffsetW-1:0] OffsetMax      = '1;
    localparam logic [OffsetW-1:0] MaxOffsetReset = OffsetW'(255);

    // parser states
    localparam logic [StateW-1:0] ST_START  = 4'd0;
    localparam logic [StateW-1:0] ST_KEY    = 4'd1;
    localparam logic [StateW-1:0] ST_COLON  = 4'd2;
    localparam logic [StateW-1:0] ST_SPACE  = 4'd3;
    localparam logic [StateW-1:0] ST_VALUE  = 4'd4;
    localparam logic [StateW-1:0] ST_CR     = 4'd5;
    localparam logic [StateW-1:0] ST_LF     = 4'd6;
    localparam logic [StateW-1:0] ST_END_CR = 4'd7;
    localparam logic [StateW-1:0] ST_END_LF = 4'd8;
    localparam logic [StateW-1:0] ST_ERROR  = 4'd9;

    // byte roles
    localparam logic [RoleW-1:0] ROLE_SKIP  = 3'd0;
    localparam logic [RoleW-1:0] ROLE_KEY   = 3'd1;
    localparam logic [RoleW-1:0] ROLE_SEP   = 3'd2;
    localparam logic [RoleW-1:0] ROLE_VALUE = 3'd3;
    localparam logic [RoleW-1:0] ROLE_LINE  = 3'd4;
    localparam logic [RoleW-1:0] ROLE_BLOCK = 3'd5;

    // characters of interest
    localparam logic [ByteW-1:0] CHAR_COLON = 8'h3A;
    localparam logic [ByteW-1:0] CHAR_SPACE = 8'h20;
    localparam logic [ByteW-1:0] CHAR_CR    = 8'h0D;
    localparam logic [ByteW-1:0] CHAR_LF    = 8'h0A;

    typedef struct packed {
        logic [ByteW-1:0] data_byte;
        logic             new_request;
    } in_item_t;

    typedef struct packed {
        logic [ByteW-1:0] byte_out;
        logic [RoleW-1:0] byte_role;
        logic             field_done;
        logic             block_done;
        logic             parse_error;
    } out_item_t;

    // parser state carried from one byte to the next
    typedef struct packed {
        logic [StateW-1:0]  parse_state;
        logic [OffsetW-1:0] value_offset;
    } parse_ctx_t;

endpackage

// File: hdl/http_header_line_parser_top.sv
// channel  | direction | handshake          | payload
// s_       | in        | s_valid / s_ready  | s_data  (hhlp_pkg::in_item_t)
// m_       | out       | m_valid / m_ready  | m_data  (hhlp_pkg::out_item_t)
// cfg_     | in        | cfg_we, no wait    | cfg_wdata (max_value_offset)
//
// one item per clock sustained while m_ready stays high; an accepted item reaches m_valid
// through the input register, then the result register
// the classifier between the two registers is a single pass over one byte
// aresetn is synchronous, active low; restores the start state and a limit of 255
// a stall on m_ready holds the result; the input register drains into it as soon
// as it frees, so s_ready drops only when both registers are full
`include "assert_macros.svh"

module http_header_line_parser_top (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  hhlp_pkg::in_item_t            s_data,

    output logic                          m_valid,
    input  logic                          m_ready,
    output hhlp_pkg::out_item_t           m_data,

    input  logic                          cfg_we,
    input  logic [hhlp_pkg::OffsetW-1:0]  cfg_wdata
);

    // input register
    logic                          in_vld_reg;
    hhlp_pkg::in_item_t            in_item_reg;

    // result register
    logic                          out_vld_reg;
    hhlp_pkg::out_item_t           out_item_reg;

    // parser context and the value length limit
    hhlp_pkg::parse_ctx_t          ctx_reg;
    hhlp_pkg::parse_ctx_t          ctx_next;
    logic [hhlp_pkg::OffsetW-1:0]  max_off_reg;

    hhlp_pkg::out_item_t           step_item;

    logic                          out_free;
    logic                          advance;

    // result slot free when empty or being taken this cycle
    assign out_free = !out_vld_reg || m_ready;
    // held byte moves through the classifier into the result register
    assign advance  = in_vld_reg && out_free;
    // input register can take a new item when empty or draining
    assign s_ready  = !in_vld_reg || out_free;

    hhlp_step u_step (
        .item_in          (in_item_reg),
        .ctx_in           (ctx_reg),
        .max_value_offset (max_off_reg),
        .ctx_out          (ctx_next),
        .item_out         (step_item)
    );

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
    end

    // result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_free) begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg <= step_item;
        end
    end

    // parser context only moves with a classified item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctx_reg.parse_state  <= hhlp_pkg::ST_START;
            ctx_reg.value_offset <= '0;
        end else if (advance) begin
            ctx_reg <= ctx_next;
        end
    end

    // limit register, to be written only while idle; the block itself does not enforce this
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_off_reg <= hhlp_pkg::MaxOffsetReset;
        end else if (cfg_we) begin
            max_off_reg <= cfg_wdata;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_item_reg;

    // error persists until a byte flagged as a new request arrives
    `HHLP_ASSERT(a_err_sticky, aclk, aresetn,
        (advance && !in_item_reg.new_request
            && ctx_reg.parse_state == hhlp_pkg::ST_ERROR)
        |=> (ctx_reg.parse_state == hhlp_pkg::ST_ERROR),
        "parse error cleared without a new request")

    // a closed block stays closed until a new request
    `HHLP_ASSERT(a_end_hold, aclk, aresetn,
        (advance && !in_item_reg.new_request
            && ctx_reg.parse_state == hhlp_pkg::ST_END_LF)
        |=> (ctx_reg.parse_state == hhlp_pkg::ST_END_LF),
        "parser left block end without a new request")

    // a completed line or block is always reported on a line end byte
    `HHLP_ASSERT(a_done_role, aclk, aresetn,
        (out_vld_reg && (out_item_reg.field_done || out_item_reg.block_done))
        |-> (out_item_reg.byte_out == hhlp_pkg::CHAR_LF && !out_item_reg.parse_error),
        "done flag on a byte that is not a clean line feed")

    // the parser context never changes without a classified item
    `HHLP_ASSERT(a_ctx_hold, aclk, aresetn,
        (!advance && $past(aresetn)) |=> $stable(ctx_reg),
        "parser context moved without an item")

endmodule

// File: hdl/hhlp_step.sv
module hhlp_step (
    input  hhlp_pkg::in_item_t             item_in,
    input  hhlp_pkg::parse_ctx_t           ctx_in,
    input  logic [hhlp_pkg::OffsetW-1:0]   max_value_offset,
    output hhlp_pkg::parse_ctx_t           ctx_out,
    output hhlp_pkg::out_item_t            item_out
);

    logic [hhlp_pkg::ByteW-1:0]   c;
    logic [hhlp_pkg::StateW-1:0]  st;
    logic [hhlp_pkg::StateW-1:0]  st_nx;
    logic [hhlp_pkg::OffsetW-1:0] off;
    logic [hhlp_pkg::OffsetW-1:0] off_nx;
    logic [hhlp_pkg::RoleW-1:0]   role;
    logic                         fdone;
    logic                         bdone;
    logic                         err;
    logic                         is_eol;

    assign c      = item_in.data_byte;
    assign is_eol = (c == hhlp_pkg::CHAR_CR) || (c == hhlp_pkg::CHAR_LF);

    always_comb begin
        // new request restarts before this byte
        st  = item_in.new_request ? hhlp_pkg::ST_START : ctx_in.parse_state;
        off = item_in.new_request ? '0 : ctx_in.value_offset;

        st_nx  = st;
        off_nx = off;
        role   = hhlp_pkg::ROLE_SKIP;
        fdone  = 1'b0;
        bdone  = 1'b0;
        err    = 1'b0;

        unique case (st)
            hhlp_pkg::ST_START: begin
                if (!is_eol) begin
                    st_nx = hhlp_pkg::ST_KEY;
                    role  = hhlp_pkg::ROLE_KEY;
                end
            end
            hhlp_pkg::ST_KEY: begin
                if (c == hhlp_pkg::CHAR_COLON) begin
                    st_nx = hhlp_pkg::ST_COLON;
                    role  = hhlp_pkg::ROLE_SEP;
                end else if (is_eol) begin
                    err = 1'b1;
                end else begin
                    role = hhlp_pkg::ROLE_KEY;
                end
            end
            hhlp_pkg::ST_COLON: begin
                if (c == hhlp_pkg::CHAR_SPACE) begin
                    st_nx = hhlp_pkg::ST_SPACE;
                    role  = hhlp_pkg::ROLE_SEP;
                end else begin
                    err = 1'b1;
                end
            end
            hhlp_pkg::ST_SPACE: begin
                // first value byte taken unchecked
                st_nx  = hhlp_pkg::ST_VALUE;
                off_nx = '0;
                role   = hhlp_pkg::ROLE_VALUE;
            end
            hhlp_pkg::ST_VALUE: begin
                if (c == hhlp_pkg::CHAR_CR) begin
                    st_nx = hhlp_pkg::ST_CR;
                    role  = hhlp_pkg::ROLE_LINE;
                end else begin
                    if (off != hhlp_pkg::OffsetMax) begin
                        off_nx = off + hhlp_pkg::OffsetW'(1);
                    end
                    if (off_nx > max_value_offset) begin
                        err = 1'b1;
                    end else begin
                        role = hhlp_pkg::ROLE_VALUE;
                    end
                end
            end
            hhlp_pkg::ST_CR: begin
                if (c == hhlp_pkg::CHAR_LF) begin
                    st_nx = hhlp_pkg::ST_LF;
                    role  = hhlp_pkg::ROLE_LINE;
                    fdone = 1'b1;
                end else begin
                    err = 1'b1;
                end
            end
            hhlp_pkg::ST_LF: begin
                if (c == hhlp_pkg::CHAR_CR) begin
                    st_nx = hhlp_pkg::ST_END_CR;
                    role  = hhlp_pkg::ROLE_BLOCK;
                end else begin
                    st_nx = hhlp_pkg::ST_KEY;
                    role  = hhlp_pkg::ROLE_KEY;
                end
            end
            hhlp_pkg::ST_END_CR: begin
                if (c == hhlp_pkg::CHAR_LF) begin
                    st_nx = hhlp_pkg::ST_END_LF;
                    role  = hhlp_pkg::ROLE_BLOCK;
                    bdone = 1'b1;
                end else begin
                    err = 1'b1;
                end
            end
            hhlp_pkg::ST_END_LF: begin
                // block closed, bytes skipped until next request
            end
            default: begin
                err = 1'b1;
            end
        endcase

        if (err) begin
            st_nx = hhlp_pkg::ST_ERROR;
            role  = hhlp_pkg::ROLE_SKIP;
        end
    end

    assign ctx_out.parse_state  = st_nx;
    assign ctx_out.value_offset = off_nx;

    assign item_out.byte_out    = c;
    assign item_out.byte_role   = role;
    assign item_out.field_done  = fdone;
    assign item_out.block_done  = bdone;
    assign item_out.parse_error = (st_nx == hhlp_pkg::ST_ERROR);

endmodule

// File: tb/tb_http_header_line_parser_top.sv
module tb_http_header_line_parser_top;
    timeunit 1ns;
    timeprecision 1ps;

    // running model of the parser: classifies each accepted byte and queues
    // the item the block should return for it
    class role_scoreboard;
        logic [hhlp_pkg::StateW-1:0]  state;
        logic [hhlp_pkg::OffsetW-1:0] offset;
        logic [hhlp_pkg::OffsetW-1:0] limit;
        hhlp_pkg::out_item_t          expected_roles[$];
        int                           failures;

        function new();
            state    = hhlp_pkg::ST_START;
            offset   = '0;
            limit    = hhlp_pkg::MaxOffsetReset;
            failures = 0;
        endfunction

        function int pending();
            return expected_roles.size();
        endfunction

        function void note_byte(hhlp_pkg::in_item_t it);
            hhlp_pkg::out_item_t        want;
            logic [hhlp_pkg::ByteW-1:0] c;
            bit                         bad;
            c    = it.data_byte;
            bad  = 1'b0;
            want = '0;
            want.byte_out  = c;
            want.byte_role = hhlp_pkg::ROLE_SKIP;
            if (it.new_request) begin
                state  = hhlp_pkg::ST_START;
                offset = '0;
            end
            case (state)
                hhlp_pkg::ST_START: begin
                    if (c != hhlp_pkg::CHAR_LF && c != hhlp_pkg::CHAR_CR) begin
                        state          = hhlp_pkg::ST_KEY;
                        want.byte_role = hhlp_pkg::ROLE_KEY;
                    end
                end
                hhlp_pkg::ST_KEY: begin
                    if (c == hhlp_pkg::CHAR_COLON) begin
                        state          = hhlp_pkg::ST_COLON;
                        want.byte_role = hhlp_pkg::ROLE_SEP;
                    end else if (c == hhlp_pkg::CHAR_LF || c == hhlp_pkg::CHAR_CR) begin
                        bad = 1'b1;
                    end else begin
                        want.byte_role = hhlp_pkg::ROLE_KEY;
                    end
                end
                hhlp_pkg::ST_COLON: begin
                    if (c == hhlp_pkg::CHAR_SPACE) begin
                        state          = hhlp_pkg::ST_SPACE;
                        want.byte_role = hhlp_pkg::ROLE_SEP;
                    end else begin
                        bad = 1'b1;
                    end
                end
                hhlp_pkg::ST_SPACE: begin
                    // first value byte is taken whatever it is
                    state          = hhlp_pkg::ST_VALUE;
                    offset         = '0;
                    want.byte_role = hhlp_pkg::ROLE_VALUE;
                end
                hhlp_pkg::ST_VALUE: begin
                    if (c == hhlp_pkg::CHAR_CR) begin
                        state          = hhlp_pkg::ST_CR;
                        want.byte_role = hhlp_pkg::ROLE_LINE;
                    end else begin
                        if (offset < hhlp_pkg::OffsetMax)
                            offset = offset + 1'b1;
                        if (offset > limit)
                            bad = 1'b1;
                        else
                            want.byte_role = hhlp_pkg::ROLE_VALUE;
                    end
                end
                hhlp_pkg::ST_CR: begin
                    if (c == hhlp_pkg::CHAR_LF) begin
                        state           = hhlp_pkg::ST_LF;
                        want.byte_role  = hhlp_pkg::ROLE_LINE;
                        want.field_done = 1'b1;
                    end else begin
                        bad = 1'b1;
                    end
                end
                hhlp_pkg::ST_LF: begin
                    if (c == hhlp_pkg::CHAR_CR) begin
                        state          = hhlp_pkg::ST_END_CR;
                        want.byte_role = hhlp_pkg::ROLE_BLOCK;
                    end else begin
                        state          = hhlp_pkg::ST_KEY;
                        want.byte_role = hhlp_pkg::ROLE_KEY;
                    end
                end
                hhlp_pkg::ST_END_CR: begin
                    if (c == hhlp_pkg::CHAR_LF) begin
                        state           = hhlp_pkg::ST_END_LF;
                        want.byte_role  = hhlp_pkg::ROLE_BLOCK;
                        want.block_done = 1'b1;
                    end else begin
                        bad = 1'b1;
                    end
                end
                hhlp_pkg::ST_END_LF: ;
                default: bad = 1'b1;
            endcase
            if (bad) begin
                state          = hhlp_pkg::ST_ERROR;
                want.byte_role = hhlp_pkg::ROLE_SKIP;
            end
            want.parse_error = (state == hhlp_pkg::ST_ERROR);
            expected_roles.push_back(want);
        endfunction

        function void check_role(hhlp_pkg::out_item_t got);
            hhlp_pkg::out_item_t want;
            if (expected_roles.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected item: byte %02h role %0d fd %0b bd %0b err %0b",
                             got.byte_out, got.byte_role, got.field_done,
                             got.block_done, got.parse_error);
                return;
            end
            want = expected_roles.pop_front();
            if (got.byte_out !== want.byte_out || got.byte_role !== want.byte_role ||
                got.field_done !== want.field_done || got.block_done !== want.block_done ||
                got.parse_error !== want.parse_error) begin
                failures++;
                if (failures <= 10)
                    $display({"role mismatch: expected %02h/%0d/%0b/%0b/%0b",
                              " got %02h/%0d/%0b/%0b/%0b"},
                             want.byte_out, want.byte_role, want.field_done,
                             want.block_done, want.parse_error,
                             got.byte_out, got.byte_role, got.field_done,
                             got.block_done, got.parse_error);
            end
        endfunction
    endclass

    // clock, reset and all block inputs start from known values
    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_valid   = 1'b0;
    logic                          s_ready;
    hhlp_pkg::in_item_t            s_data    = '0;
    logic                          m_valid;
    logic                          m_ready   = 1'b0;
    hhlp_pkg::out_item_t           m_data;
    logic                          cfg_we    = 1'b0;
    logic [hhlp_pkg::OffsetW-1:0]  cfg_wdata = '0;

    role_scoreboard sb = new();

    // idling odds in percent, changed between phases
    int src_idle_pct  = 12;
    int sink_idle_pct = 81;
    int items_sent    = 0;

    // bytes of the header block being sent next
    hhlp_pkg::in_item_t block_bytes[$];
    bit                 next_new_req;
    bit                 long_done = 1'b0;

    http_header_line_parser_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // result side: check on each handshake, then pick the next ready level
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_role(m_data);
        m_ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // hard stop in case the block hangs
    initial begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // random byte that is neither CR nor LF, optionally not ':' either
    function automatic logic [hhlp_pkg::ByteW-1:0] key_byte(bit no_colon);
        logic [hhlp_pkg::ByteW-1:0] b;
        do
            b = hhlp_pkg::ByteW'($urandom_range(255));
        while (b == hhlp_pkg::CHAR_CR || b == hhlp_pkg::CHAR_LF ||
               (no_colon && b == hhlp_pkg::CHAR_COLON));
        return b;
    endfunction

    // random byte that does not end a value
    function automatic logic [hhlp_pkg::ByteW-1:0] value_byte();
        logic [hhlp_pkg::ByteW-1:0] b;
        do
            b = hhlp_pkg::ByteW'($urandom_range(255));
        while (b == hhlp_pkg::CHAR_CR);
        return b;
    endfunction

    // append one byte; the request flag is raised when asked for and,
    // very rarely, in the middle of a block
    function automatic void push_byte(logic [hhlp_pkg::ByteW-1:0] b);
        hhlp_pkg::in_item_t it;
        it.data_byte   = b;
        it.new_request = next_new_req || ($urandom_range(299) == 0);
        next_new_req   = 1'b0;
        block_bytes.push_back(it);
    endfunction

    // offer one item and hold it until it is taken
    task automatic send_item(hhlp_pkg::in_item_t it);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do
            @(posedge aclk);
        while (!s_ready);
        sb.note_byte(it);
        items_sent++;
    endtask

    task automatic send_block();
        foreach (block_bytes[i])
            send_item(block_bytes[i]);
    endtask

    // stop offering and let every outstanding result come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    task automatic set_value_limit(logic [hhlp_pkg::OffsetW-1:0] lim);
        cfg_we    <= 1'b1;
        cfg_wdata <= lim;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.limit  = lim;
    endtask

    // one header block: optional leading CR/LF, a few key: value lines,
    // usually the closing blank line, then sometimes damage and noise
    task automatic build_header_block(bit long_value);
        int n_lines;
        int key_len;
        int val_len;
        int cap;
        int idx;
        block_bytes.delete();
        next_new_req = ($urandom_range(9) != 0);
        repeat ($urandom_range(0, 2))
            push_byte($urandom_range(1) ? hhlp_pkg::CHAR_CR : hhlp_pkg::CHAR_LF);
        n_lines = long_value ? 1 : $urandom_range(0, 4);
        for (int l = 0; l < n_lines; l++) begin
            key_len = $urandom_range(1, 6);
            // a ':' as first key byte is still a key byte
            push_byte(($urandom_range(9) == 0) ? hhlp_pkg::CHAR_COLON : key_byte(1'b0));
            for (int k = 1; k < key_len; k++)
                push_byte(key_byte(1'b1));
            push_byte(hhlp_pkg::CHAR_COLON);
            push_byte(hhlp_pkg::CHAR_SPACE);
            cap = (sb.limit < 12) ? int'(sb.limit) + 2 : 12;
            if (long_value)
                val_len = 1030;
            else if ($urandom_range(9) == 0 && sb.limit <= 64)
                val_len = int'(sb.limit) + int'($urandom_range(0, 3));
            else
                val_len = $urandom_range(1, cap);
            if (val_len < 1)
                val_len = 1;
            // first value byte may even be a CR
            push_byte(($urandom_range(7) == 0) ? hhlp_pkg::CHAR_CR : value_byte());
            for (int v = 1; v < val_len; v++)
                push_byte(value_byte());
            push_byte(hhlp_pkg::CHAR_CR);
            push_byte(hhlp_pkg::CHAR_LF);
        end
        if ($urandom_range(99) < 85) begin
            push_byte(hhlp_pkg::CHAR_CR);
            push_byte(hhlp_pkg::CHAR_LF);
        end
        repeat ($urandom_range(0, 2))
            push_byte(hhlp_pkg::ByteW'($urandom_range(255)));
        if (block_bytes.size() > 0 && $urandom_range(4) == 0) begin
            idx = $urandom_range(block_bytes.size() - 1);
            block_bytes[idx].data_byte = hhlp_pkg::ByteW'($urandom_range(255));
        end
        if ($urandom_range(19) == 0) begin
            repeat ($urandom_range(1, 8)) begin
                next_new_req = $urandom_range(1);
                push_byte(hhlp_pkg::ByteW'($urandom_range(255)));
            end
        end
    endtask

    // one phase of random blocks at a given idling mix and value limit
    task automatic run_phase(int src_pct, int sink_pct, logic [hhlp_pkg::OffsetW-1:0] lim,
                             bit with_long, int target_total);
        int start;
        wait_drained();
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        set_value_limit(lim);
        start = items_sent;
        while (items_sent - start < 80 || items_sent < target_total) begin
            build_header_block(with_long && !long_done);
            if (with_long)
                long_done = 1'b1;
            send_block();
        end
    endtask

    // hand-picked sequence, run at the reset limit of 255
    task automatic directed_bytes();
        block_bytes.delete();
        next_new_req = 1'b1;
        push_byte(hhlp_pkg::CHAR_CR);      // leading CR skipped
        push_byte(hhlp_pkg::CHAR_LF);      // leading LF skipped
        push_byte(hhlp_pkg::CHAR_COLON);   // key start: ':' is a key byte
        push_byte(8'hFF);
        push_byte(hhlp_pkg::CHAR_COLON);
        push_byte(hhlp_pkg::CHAR_SPACE);
        push_byte(hhlp_pkg::CHAR_CR);      // first value byte, even a CR
        push_byte(8'h00);
        push_byte(hhlp_pkg::CHAR_LF);      // LF inside a value
        push_byte(hhlp_pkg::CHAR_CR);
        push_byte(hhlp_pkg::CHAR_LF);      // field done
        push_byte(hhlp_pkg::CHAR_LF);      // byte after a line: LF starts a key
        push_byte(hhlp_pkg::CHAR_COLON);
        push_byte(hhlp_pkg::CHAR_SPACE);
        push_byte(8'h76);
        push_byte(hhlp_pkg::CHAR_CR);
        push_byte(hhlp_pkg::CHAR_LF);
        push_byte(hhlp_pkg::CHAR_CR);      // blank line
        push_byte(hhlp_pkg::CHAR_LF);      // block done
        push_byte(8'h78);                  // after block end: skipped
        next_new_req = 1'b1;
        push_byte(8'h6B);
        push_byte(hhlp_pkg::CHAR_CR);      // CR inside a key: error
        push_byte(8'h61);                  // error stays set
        next_new_req = 1'b1;
        push_byte(8'h6B);                  // new request clears it
        push_byte(hhlp_pkg::CHAR_COLON);
        push_byte(8'h78);                  // no space after ':'
        send_block();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // sender lazy, receiver stalling a lot
        directed_bytes();
        run_phase(12, 81, hhlp_pkg::OffsetW'(1), 1'b0, 110);
        run_phase(12, 81, hhlp_pkg::OffsetW'(1023), 1'b0, 220);
        // sender stalling a lot, receiver lazy
        run_phase(81, 12, hhlp_pkg::OffsetW'($urandom_range(2, 40)), 1'b0, 330);
        run_phase(81, 12, hhlp_pkg::OffsetW'(255), 1'b0, 440);
        // full rate; one value long enough to saturate the offset
        run_phase(0, 0, hhlp_pkg::OffsetW'(1023), 1'b1, 1460);
        run_phase(0, 0, hhlp_pkg::OffsetW'($urandom_range(2, 40)), 1'b0, 1550);

        wait_drained();
        // a few more cycles so that any stray item would show up
        repeat (8) @(posedge aclk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
